### hw/rtl/nba_pkg.sv
// ----------------------------------------------------------------------------
// nba_pkg
// Shared types and constants for the named block allocator: command and
// status codes, scan modes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package nba_pkg;

   localparam int NAME_BYTES = 32;
   localparam int NAME_BITS  = 256;

   localparam logic [2:0] OP_FORMAT = 3'd0;
   localparam logic [2:0] OP_CREATE = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_WRITE  = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;
   localparam logic [2:0] OP_LIST   = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXISTS    = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef enum logic [1:0] {
      SCAN_NAME,
      SCAN_FREE,
      SCAN_USED
   } scan_mode_type;

   typedef struct packed {
      logic          load;
      logic          format;
      logic          scan_start;
      scan_mode_type scan_mode;
      logic          clr_start;
      logic          clr_step;
      logic          commit;
      logic          free_slot;
      logic          write_byte;
      logic          read_issue;
      logic          rsp_load;
      logic [1:0]    rsp_status;
      logic          show_slot;
      logic          show_name;
      logic          show_read;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       scan_hit;
      logic       scan_miss;
      logic       clr_last;
      logic       rsp_free;
   } dp_stat_type;

endpackage

### hw/rtl/nba_ram.sv
// ----------------------------------------------------------------------------
// nba_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module nba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/nba_ctrl.sv
// ----------------------------------------------------------------------------
// nba_ctrl
// Command sequencer: dispatches each accepted word to format, lookup, first-fit
// search, content clear, byte access or list scan, then loads the response.
// ----------------------------------------------------------------------------
module nba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  nba_pkg::dp_stat_type stat,
   output nba_pkg::dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_LOOKUP,
      S_HIT,
      S_FREE_SCAN,
      S_CLEAR,
      S_LIST,
      S_READ_WAIT,
      S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       show_slot_ff, show_slot_in;
   logic       show_name_ff, show_name_in;
   logic       show_read_ff, show_read_in;

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      show_slot_in = show_slot_ff;
      show_name_in = show_name_ff;
      show_read_in = show_read_ff;
      cmd          = '0;
      cmd.scan_mode  = nba_pkg::SCAN_NAME;
      cmd.rsp_status = status_ff;
      cmd.show_slot  = show_slot_ff;
      cmd.show_name  = show_name_ff;
      cmd.show_read  = show_read_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load     = 1'b1;
               status_in    = nba_pkg::ST_OK;
               show_slot_in = 1'b0;
               show_name_in = 1'b0;
               show_read_in = 1'b0;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority case (stat.op)
               nba_pkg::OP_FORMAT: begin
                  cmd.format = 1'b1;
                  state_in   = S_FINISH;
               end
               nba_pkg::OP_CREATE, nba_pkg::OP_DELETE,
               nba_pkg::OP_WRITE, nba_pkg::OP_READ: begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_mode  = nba_pkg::SCAN_NAME;
                  state_in       = S_LOOKUP;
               end
               nba_pkg::OP_LIST: begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_mode  = nba_pkg::SCAN_USED;
                  state_in       = S_LIST;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_LOOKUP: begin
            if (stat.scan_hit) begin
               show_slot_in = 1'b1;
               state_in     = S_HIT;
            end else if (stat.scan_miss) begin
               if (stat.op == nba_pkg::OP_CREATE) begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_mode  = nba_pkg::SCAN_FREE;
                  state_in       = S_FREE_SCAN;
               end else begin
                  status_in = nba_pkg::ST_NOT_FOUND;
                  state_in  = S_FINISH;
               end
            end
         end
         S_HIT: begin
            priority case (stat.op)
               nba_pkg::OP_CREATE: begin
                  status_in = nba_pkg::ST_EXISTS;
                  state_in  = S_FINISH;
               end
               nba_pkg::OP_DELETE: begin
                  cmd.free_slot = 1'b1;
                  state_in      = S_FINISH;
               end
               nba_pkg::OP_WRITE: begin
                  cmd.write_byte = 1'b1;
                  state_in       = S_FINISH;
               end
               default: begin
                  cmd.read_issue = 1'b1;
                  show_read_in   = 1'b1;
                  state_in       = S_READ_WAIT;
               end
            endcase
         end
         S_FREE_SCAN: begin
            if (stat.scan_hit) begin
               cmd.clr_start = 1'b1;
               state_in      = S_CLEAR;
            end else if (stat.scan_miss) begin
               status_in = nba_pkg::ST_FULL;
               state_in  = S_FINISH;
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               cmd.commit   = 1'b1;
               show_slot_in = 1'b1;
               state_in     = S_FINISH;
            end
         end
         S_LIST: begin
            if (stat.scan_hit) begin
               show_slot_in = 1'b1;
               show_name_in = 1'b1;
               state_in     = S_FINISH;
            end else if (stat.scan_miss) begin
               status_in = nba_pkg::ST_NOT_FOUND;
               state_in  = S_FINISH;
            end
         end
         S_READ_WAIT: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= nba_pkg::ST_OK;
         show_slot_ff <= 1'b0;
         show_name_ff <= 1'b0;
         show_read_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         show_slot_ff <= show_slot_in;
         show_name_ff <= show_name_in;
         show_read_ff <= show_read_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

### hw/rtl/nba_dp.sv
// ----------------------------------------------------------------------------
// nba_dp
// Datapath: request capture, used map, pipelined slot scan over the name
// RAM, length and content RAMs, clear sweep and the response register.
// ----------------------------------------------------------------------------
module nba_dp #(
   parameter int NUM_SLOTS      = 128,
   parameter int RESERVED_SLOTS = 10,
   parameter int CONTENT_BYTES  = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  nba_pkg::dp_cmd_type cmd,
   output nba_pkg::dp_stat_type stat,
   input  logic [2:0]          req_command,
   input  logic [63:0]         req_name_word_0,
   input  logic [63:0]         req_name_word_1,
   input  logic [63:0]         req_name_word_2,
   input  logic [63:0]         req_name_word_3,
   input  logic [7:0]          req_byte_offset,
   input  logic [7:0]          req_write_data,
   input  logic                req_final_byte,
   input  logic [6:0]          req_start_slot,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [6:0]          rsp_slot_index,
   output logic [7:0]          rsp_read_data,
   output logic [63:0]         rsp_list_name_0,
   output logic [63:0]         rsp_list_name_1,
   output logic [63:0]         rsp_list_name_2,
   output logic [63:0]         rsp_list_name_3
);

   localparam int AW  = $clog2(NUM_SLOTS);
   localparam int CW  = $clog2(NUM_SLOTS + 1);
   localparam int SW  = (CW > 7) ? CW : 7;
   localparam int OW  = $clog2(CONTENT_BYTES);
   localparam int CAW = $clog2(NUM_SLOTS * CONTENT_BYTES);
   localparam int NB  = nba_pkg::NAME_BITS;
   localparam int LW  = $clog2(CONTENT_BYTES + 1);
   localparam logic [SW-1:0] NUM_W = SW'(NUM_SLOTS);
   localparam logic [SW-1:0] RES_W = SW'(RESERVED_SLOTS);
   localparam logic [OW-1:0] CLR_LAST = OW'(CONTENT_BYTES - 1);

   // request capture
   logic [2:0]    op_ff;
   logic [NB-1:0] name_ff, name_clean, name_raw;
   logic [7:0]    off_ff;
   logic [7:0]    wdata_ff;
   logic          final_ff;
   logic [6:0]    start_ff;

   logic [NUM_SLOTS-1:0] used_ff, used_in;

   // scan
   logic          scan_act_ff;
   logic [SW-1:0] scan_cnt_ff;
   logic          cmp_v_ff;
   logic [AW-1:0] cmp_addr_ff;
   nba_pkg::scan_mode_type mode_ff;
   logic          issue, match, hit, miss;
   logic [SW-1:0] list_start;

   logic [AW-1:0] slot_ff;
   logic [NB-1:0] hit_name_ff;
   logic [OW-1:0] clr_cnt_ff;

   logic [NB-1:0]  name_rd;
   logic [LW-1:0]  len_rd;
   logic [7:0]     byte_rd;
   logic           off_ok;
   logic [CAW-1:0] base_addr, byte_addr, cw_addr;
   logic           cw_en;
   logic [7:0]     cw_data;
   logic           lw_en;
   logic [LW-1:0]  lw_data;
   logic [SW-1:0]  slot_wide;
   logic [7:0]     rd_value;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [6:0]    rsp_slot_ff;
   logic [7:0]    rsp_read_ff;
   logic [NB-1:0] rsp_name_ff;

   assign name_raw = {req_name_word_3, req_name_word_2, req_name_word_1, req_name_word_0};

   // name ends at the first zero byte; the last name byte position is always zero
   always_comb begin
      logic       alive;
      logic [7:0] b;
      alive = 1'b1;
      name_clean = '0;
      for (int i = 0; i < NB / 8; i++) begin
         b = name_raw[8*i +: 8];
         if (b == 8'd0 || i >= nba_pkg::NAME_BYTES - 1) begin
            alive = 1'b0;
         end
         name_clean[8*i +: 8] = alive ? b : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_command;
         name_ff  <= name_clean;
         off_ff   <= req_byte_offset;
         wdata_ff <= req_write_data;
         final_ff <= req_final_byte;
         start_ff <= req_start_slot;
      end
   end

   always_comb begin
      used_in = used_ff;
      if (cmd.format) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            used_in[i] = (i < RESERVED_SLOTS);
         end
      end else if (cmd.commit) begin
         used_in[slot_ff] = 1'b1;
      end else if (cmd.free_slot) begin
         used_in[slot_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            used_ff[i] <= (i < RESERVED_SLOTS);
         end
      end else begin
         used_ff <= used_in;
      end
   end

   // scan pipeline: issue a name read per cycle, compare in the cycle after
   assign list_start = (SW'(start_ff) < RES_W) ? RES_W : SW'(start_ff);
   assign issue = scan_act_ff && (scan_cnt_ff < NUM_W);

   always_comb begin
      unique case (mode_ff)
         nba_pkg::SCAN_NAME: match = used_ff[cmp_addr_ff] && (name_rd == name_ff);
         nba_pkg::SCAN_FREE: match = !used_ff[cmp_addr_ff];
         nba_pkg::SCAN_USED: match = used_ff[cmp_addr_ff];
         default:            match = 1'b0;
      endcase
   end

   assign hit  = scan_act_ff && cmp_v_ff && match;
   assign miss = scan_act_ff && !cmp_v_ff && (scan_cnt_ff >= NUM_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_act_ff <= 1'b0;
         cmp_v_ff    <= 1'b0;
      end else if (cmd.scan_start) begin
         scan_act_ff <= 1'b1;
         cmp_v_ff    <= 1'b0;
      end else begin
         if (hit || miss) begin
            scan_act_ff <= 1'b0;
         end
         cmp_v_ff <= issue && !hit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         mode_ff     <= cmd.scan_mode;
         scan_cnt_ff <= (cmd.scan_mode == nba_pkg::SCAN_USED) ? list_start : RES_W;
      end else if (issue) begin
         scan_cnt_ff <= scan_cnt_ff + SW'(1);
      end
      if (issue) begin
         cmp_addr_ff <= scan_cnt_ff[AW-1:0];
      end
      if (hit) begin
         slot_ff     <= cmp_addr_ff;
         hit_name_ff <= name_rd;
      end
      if (cmd.clr_start) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= clr_cnt_ff + OW'(1);
      end
   end

   // content addressing
   assign off_ok    = (int'(off_ff) < CONTENT_BYTES);
   assign base_addr = CAW'(slot_ff) * CAW'(CONTENT_BYTES);
   assign byte_addr = base_addr + CAW'(off_ff);
   assign cw_en     = cmd.clr_step || (cmd.write_byte && off_ok);
   assign cw_addr   = cmd.clr_step ? (base_addr + CAW'(clr_cnt_ff)) : byte_addr;
   assign cw_data   = cmd.clr_step ? 8'd0 : wdata_ff;
   assign lw_en     = cmd.commit || (cmd.write_byte && off_ok && final_ff);
   assign lw_data   = cmd.commit ? '0 : (LW'(off_ff) + LW'(1));

   nba_ram #(.WIDTH(NB), .DEPTH(NUM_SLOTS)) u_name_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (slot_ff),
      .wr_data (name_ff),
      .rd_en   (issue),
      .rd_addr (scan_cnt_ff[AW-1:0]),
      .rd_data (name_rd)
   );

   nba_ram #(.WIDTH(LW), .DEPTH(NUM_SLOTS)) u_len_ram (
      .clock   (clock),
      .wr_en   (lw_en),
      .wr_addr (slot_ff),
      .wr_data (lw_data),
      .rd_en   (cmd.read_issue),
      .rd_addr (slot_ff),
      .rd_data (len_rd)
   );

   nba_ram #(.WIDTH(8), .DEPTH(NUM_SLOTS * CONTENT_BYTES)) u_content_ram (
      .clock   (clock),
      .wr_en   (cw_en),
      .wr_addr (cw_addr),
      .wr_data (cw_data),
      .rd_en   (cmd.read_issue),
      .rd_addr (byte_addr),
      .rd_data (byte_rd)
   );

   // response register
   assign slot_wide = SW'(slot_ff);
   assign rd_value  = (off_ok && (LW'(off_ff) < len_rd)) ? byte_rd : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_slot_ff   <= cmd.show_slot ? slot_wide[6:0] : 7'd0;
         rsp_read_ff   <= cmd.show_read ? rd_value : 8'd0;
         rsp_name_ff   <= cmd.show_name ? hit_name_ff : '0;
      end
   end

   assign stat.op        = op_ff;
   assign stat.scan_hit  = hit;
   assign stat.scan_miss = miss;
   assign stat.clr_last  = (clr_cnt_ff == CLR_LAST);
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_read_data   = rsp_read_ff;
   assign rsp_list_name_0 = rsp_name_ff[63:0];
   assign rsp_list_name_1 = rsp_name_ff[127:64];
   assign rsp_list_name_2 = rsp_name_ff[191:128];
   assign rsp_list_name_3 = rsp_name_ff[255:192];

endmodule

### hw/rtl/named_block_allocator.sv
// ----------------------------------------------------------------------------
// named_block_allocator
// Flat directory of one-block files: format, create, delete, byte write,
// byte read and list-next over a slot table with name lookup.
//
//   channel  dir  handshake          payload
//   req_     in   req_valid/stall    command, name words, offset, data, final
//   rsp_     out  rsp_valid/stall    status, slot, read data, listed name
//
// One word at a time. Scans read one slot per cycle through the name RAM;
// delete, write and read run a name lookup, and list runs a scan of used slots.
// Create runs a lookup and, on a miss, a first-fit scan; a found free slot gets
// a clear of all CONTENT_BYTES bytes of its block before it is committed.
// Format and unknown commands run no scan.
// Synchronous reset restores the used map; no clearing pass is needed.
// A stalled response holds; the next word is taken while it waits.
// ----------------------------------------------------------------------------
module named_block_allocator #(
   parameter int NUM_SLOTS      = 128,
   parameter int RESERVED_SLOTS = 10,
   parameter int CONTENT_BYTES  = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [63:0] req_name_word_0,
   input  logic [63:0] req_name_word_1,
   input  logic [63:0] req_name_word_2,
   input  logic [63:0] req_name_word_3,
   input  logic [7:0]  req_byte_offset,
   input  logic [7:0]  req_write_data,
   input  logic        req_final_byte,
   input  logic [6:0]  req_start_slot,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_slot_index,
   output logic [7:0]  rsp_read_data,
   output logic [63:0] rsp_list_name_0,
   output logic [63:0] rsp_list_name_1,
   output logic [63:0] rsp_list_name_2,
   output logic [63:0] rsp_list_name_3
);

   nba_pkg::dp_cmd_type  cmd;
   nba_pkg::dp_stat_type stat;

   nba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   nba_dp #(
      .NUM_SLOTS      (NUM_SLOTS),
      .RESERVED_SLOTS (RESERVED_SLOTS),
      .CONTENT_BYTES  (CONTENT_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_command     (req_command),
      .req_name_word_0 (req_name_word_0),
      .req_name_word_1 (req_name_word_1),
      .req_name_word_2 (req_name_word_2),
      .req_name_word_3 (req_name_word_3),
      .req_byte_offset (req_byte_offset),
      .req_write_data  (req_write_data),
      .req_final_byte  (req_final_byte),
      .req_start_slot  (req_start_slot),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_read_data   (rsp_read_data),
      .rsp_list_name_0 (rsp_list_name_0),
      .rsp_list_name_1 (rsp_list_name_1),
      .rsp_list_name_2 (rsp_list_name_2),
      .rsp_list_name_3 (rsp_list_name_3)
   );

endmodule
